// ===== rtl/mppo_pkg.sv =====
// ----------------------------------------------------------------------------
// mppo_pkg: shared types and constants of the tracker
// Holds the register codes, reset values and the structs that pass between
// the top level and the tracker core.
// ----------------------------------------------------------------------------
package mppo_pkg;

    localparam int SAMPLE_W = 15;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int POWER_W  = 32;
    localparam int CODE_W   = 12;
    localparam int STREAK_W = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CODE_W-1:0]   DAC_MAX        = 12'd4095;
    localparam logic [CODE_W-1:0]   STEP_MAX       = 12'd4095;
    localparam logic [CODE_W-1:0]   SETPOINT_RESET = 12'd800;
    localparam logic [CODE_W-1:0]   STEP_RESET     = 12'd32;
    localparam logic [CODE_W-1:0]   BASE_RESET     = 12'd32;
    localparam logic [CODE_W-1:0]   MAX_RESET      = 12'd128;
    localparam logic [STREAK_W-1:0] LIMIT_RESET    = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAK_LIMIT = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0]   base_step;
        logic [CODE_W-1:0]   max_step;
        logic [STREAK_W-1:0] streak_limit;
    } t_cfg;

    typedef struct packed {
        logic [CODE_W-1:0]  step_size;
        logic               moving_up;
        logic [POWER_W-1:0] window_power;
        logic [CODE_W-1:0]  dac_code;
    } t_result;

endpackage

// ===== rtl/mppo_tracker.sv =====
// ----------------------------------------------------------------------------
// mppo_tracker: window accumulator and step controller
// Accumulates power products, and at the end of each window decides the
// direction, moves the setpoint and adapts the step.
// ----------------------------------------------------------------------------
module mppo_tracker #(
    parameter int SAMPLES_PER_WINDOW = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mppo_pkg::t_cfg                  i_cfg,
    input  logic                            i_fire,
    input  logic [mppo_pkg::PROD_W-1:0]     i_prod,
    output logic                            o_finish,
    output mppo_pkg::t_result               o_result
);
    import mppo_pkg::*;

    localparam int IDX_W = $clog2(SAMPLES_PER_WINDOW + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES_PER_WINDOW - 1);

    logic [POWER_W-1:0]  r_sum, n_sum;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [POWER_W-1:0]  r_prev, n_prev;
    logic                r_dir, n_dir;
    logic                r_prior, n_prior;
    logic [STREAK_W-1:0] r_streak, n_streak;
    logic [CODE_W-1:0]   r_step, n_step;
    logic [CODE_W-1:0]   r_sp, n_sp;

    logic [POWER_W-1:0]  win;
    logic                drop;
    logic                dir;
    logic [STREAK_W-1:0] streak1;
    logic [CODE_W:0]     sp_up;
    logic [CODE_W:0]     step_dbl;

    always_comb begin
        win      = r_sum + POWER_W'(i_prod);
        o_finish = (r_idx == IDX_LAST);
        drop     = (win < r_prev);
        dir      = r_dir ^ drop;
        streak1  = drop ? '0 : r_streak + 1'b1;
        sp_up    = {1'b0, r_sp} + {1'b0, r_step};
        step_dbl = {r_step, 1'b0};

        n_sum    = r_sum;
        n_idx    = r_idx;
        n_prev   = r_prev;
        n_dir    = r_dir;
        n_prior  = r_prior;
        n_streak = r_streak;
        n_step   = r_step;
        n_sp     = r_sp;

        if (i_fire) begin
            if (!o_finish) begin
                n_sum = win;
                n_idx = r_idx + 1'b1;
            end else begin
                n_sum    = '0;
                n_idx    = '0;
                n_prev   = win;
                n_dir    = dir;
                n_streak = streak1;
                if (dir) begin
                    n_sp = (sp_up < {1'b0, DAC_MAX}) ? sp_up[CODE_W-1:0] : DAC_MAX;
                end else begin
                    n_sp = (r_sp > r_step) ? r_sp - r_step : '0;
                end
                if (dir == r_prior) begin
                    if (streak1 >= i_cfg.streak_limit) begin
                        if (r_step < i_cfg.max_step) begin
                            n_step = step_dbl[CODE_W] ? STEP_MAX : step_dbl[CODE_W-1:0];
                        end
                        n_streak = '0;
                    end
                end else begin
                    if (r_step > i_cfg.base_step) begin
                        n_step = r_step >> 1;
                    end
                    n_prior = dir;
                end
            end
        end
    end

    always_comb begin
        o_result.dac_code     = n_sp;
        o_result.window_power = win;
        o_result.moving_up    = n_dir;
        o_result.step_size    = n_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_idx    <= '0;
            r_prev   <= '0;
            r_dir    <= 1'b1;
            r_prior  <= 1'b1;
            r_streak <= '0;
            r_step   <= STEP_RESET;
            r_sp     <= SETPOINT_RESET;
        end else begin
            r_sum    <= n_sum;
            r_idx    <= n_idx;
            r_prev   <= n_prev;
            r_dir    <= n_dir;
            r_prior  <= n_prior;
            r_streak <= n_streak;
            r_step   <= n_step;
            r_sp     <= n_sp;
        end
    end

endmodule

// ===== rtl/mppt_perturb_observe_adaptive.sv =====
// ----------------------------------------------------------------------------
// mppt_perturb_observe_adaptive: perturb-and-observe tracker, variable step
// Sums shunt times bus voltage over a window of samples and emits a new DAC
// setpoint, the window power, the direction and the adapted step per window.
//
//   Channel   Dir   Width  Contents
//   s_axis    in    32     sample item: shunt and bus voltage
//   m_axis    out   64     window item: code, power, direction, step
//   cfg       in    12     base_step, max_step, streak_limit writes
//
// One item is accepted per cycle while the pipe is not stalled. A sample
// passes an input register, a product register and the accumulate stage;
// the output register takes a window item as its last sample is accumulated.
// Reset is synchronous and restores valid flags, tracker state and settings.
// A waiting window item stalls the pipe only when the next finishing
// sample reaches the accumulate stage; other samples keep flowing.
// ----------------------------------------------------------------------------
module mppt_perturb_observe_adaptive #(
    parameter int SAMPLES_PER_WINDOW = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mppo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mppo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [14:0] shunt sample, [29:15] bus sample, [31:30] zero
    input  logic [31:0]                         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [11:0] dac_code, [43:12] window_power, [44] moving_up,
    // [56:45] step_size, [63:57] zero
    output logic [63:0]                         m_axis_tdata
);
    import mppo_pkg::*;

    t_cfg                r_cfg;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sv;
    logic [SAMPLE_W-1:0] r_bv;
    logic                r_prod_valid;
    logic [PROD_W-1:0]   r_prod;
    logic                r_out_valid;
    t_result             r_out;

    logic                advance;
    logic                fire;
    logic                finish;
    t_result             result;

    mppo_tracker #(
        .SAMPLES_PER_WINDOW(SAMPLES_PER_WINDOW)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_fire   (fire),
        .i_prod   (r_prod),
        .o_finish (finish),
        .o_result (result)
    );

    always_comb begin
        advance       = !(r_prod_valid && finish && r_out_valid && !m_axis_tready);
        fire          = advance && r_prod_valid;
        s_axis_tready = advance || !r_in_valid;
        m_axis_tvalid = r_out_valid;
        m_axis_tdata  = {7'd0, r_out};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_step    <= BASE_RESET;
            r_cfg.max_step     <= MAX_RESET;
            r_cfg.streak_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_STEP:    r_cfg.base_step    <= i_cfg_data;
                CFG_MAX_STEP:     r_cfg.max_step     <= i_cfg_data;
                CFG_STREAK_LIMIT: r_cfg.streak_limit <= i_cfg_data[STREAK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_prod_valid <= r_in_valid;
            end
            if (fire && finish) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_sv <= s_axis_tdata[SAMPLE_W-1:0];
            r_bv <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (advance && r_in_valid) begin
            r_prod <= r_sv * r_bv;
        end
        if (fire && finish) begin
            r_out <= result;
        end
    end

endmodule

// ===== rtl/mppo_checker.sv =====
// ----------------------------------------------------------------------------
// mppo_checker: port-level checks of the tracker
// Watches output stability and padding, input readiness and the reset state.
// ----------------------------------------------------------------------------
module mppo_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("Stalled output item changed.");

    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[63:57] == 7'd0))
        else $error("Output padding bits are not zero.");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("Input stalled while the output register is empty.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output item present right after reset.");

endmodule

bind mppt_perturb_observe_adaptive mppo_checker u_mppo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_mppt_perturb_observe_adaptive.sv =====
// ----------------------------------------------------------------------------
// tb_mppt_perturb_observe_adaptive: self-checking bench for the MPPT tracker
// Drives sample items on the input stream and collects window items on the
// output stream, with random idle bursts on both sides, a long output
// hold-off and several register settings. A predictor of the tracker works
// out the window item that each finishing sample must produce, and every
// window item that comes out is compared field by field with it.
// ----------------------------------------------------------------------------
module tb_mppt_perturb_observe_adaptive;
    import mppo_pkg::*;

    localparam int WINDOW_LEN   = 4;
    localparam int MAX_SAMPLE   = 32767;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] bus;
        logic [SAMPLE_W-1:0] shunt;
    } t_sample;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [63:0]           m_axis_tdata;

    t_sample sample_q[$];
    t_result window_q[$];

    t_cfg                trk_cfg;
    logic [POWER_W-1:0]  acc_power;
    logic [POWER_W-1:0]  last_power;
    logic [3:0]          acc_count;
    logic                heading_up;
    logic                prior_up;
    logic [STREAK_W-1:0] streak_cnt;
    logic [CODE_W-1:0]   cur_step;
    logic [CODE_W-1:0]   dac_pos;

    bit          offer_busy  = 1'b0;
    bit          hold_go     = 1'b0;
    bit          hold_seen   = 1'b0;
    int          tx_gap      = 0;
    int          rx_gap      = 0;
    int          hold_left   = 0;
    int          idle_pct    = 0;
    int          fail_count  = 0;
    int          walk_level  = 16000;
    int unsigned cycle_count = 0;

    mppt_perturb_observe_adaptive #(
        .SAMPLES_PER_WINDOW(WINDOW_LEN)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Accumulates one sample and, when it closes a window, queues the window item.
    function automatic void track_sample(t_sample smp);
        logic [CODE_W:0] wide;
        t_result         res;
        acc_power = acc_power + POWER_W'(smp.shunt) * POWER_W'(smp.bus);
        acc_count = acc_count + 1'b1;
        if (acc_count < WINDOW_LEN) begin
            return;
        end
        if (acc_power < last_power) begin
            heading_up = ~heading_up;
            streak_cnt = '0;
        end else begin
            streak_cnt = streak_cnt + 1'b1;
        end
        if (heading_up) begin
            wide = {1'b0, dac_pos} + {1'b0, cur_step};
            dac_pos = (wide < DAC_MAX) ? wide[CODE_W-1:0] : DAC_MAX;
        end else begin
            dac_pos = (dac_pos > cur_step) ? dac_pos - cur_step : '0;
        end
        res.window_power = acc_power;
        last_power = acc_power;
        acc_power = '0;
        acc_count = '0;
        if (heading_up == prior_up) begin
            if (streak_cnt >= trk_cfg.streak_limit) begin
                if (cur_step < trk_cfg.max_step) begin
                    wide = {cur_step, 1'b0};
                    cur_step = (wide > STEP_MAX) ? STEP_MAX : wide[CODE_W-1:0];
                end
                streak_cnt = '0;
            end
        end else begin
            if (cur_step > trk_cfg.base_step) begin
                cur_step = cur_step >> 1;
            end
            prior_up = heading_up;
        end
        res.dac_code  = dac_pos;
        res.moving_up = heading_up;
        res.step_size = cur_step;
        window_q.push_back(res);
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endfunction

    function automatic void push_sample(int shunt, int bus);
        t_sample smp;
        smp.shunt = shunt[SAMPLE_W-1:0];
        smp.bus   = bus[SAMPLE_W-1:0];
        sample_q.push_back(smp);
    endfunction

    function automatic void push_noise(int count);
        for (int i = 0; i < count; i++) begin
            push_sample($urandom_range(0, MAX_SAMPLE), $urandom_range(0, MAX_SAMPLE));
        end
    endfunction

    // Whole windows whose power follows a random walk; at 0 or 100 percent the
    // walk is strictly monotonic until it hits a rail.
    function automatic void push_trend(int windows, int up_pct, int max_delta);
        int jitter;
        int bus;
        for (int w = 0; w < windows; w++) begin
            if ($urandom_range(0, 99) < up_pct) begin
                walk_level += int'($urandom_range(100, max_delta));
            end else begin
                walk_level -= int'($urandom_range(100, max_delta));
            end
            if (walk_level > MAX_SAMPLE) begin
                walk_level = MAX_SAMPLE;
            end
            if (walk_level < 0) begin
                walk_level = 0;
            end
            for (int s = 0; s < WINDOW_LEN; s++) begin
                jitter = (up_pct > 0 && up_pct < 100) ? int'($urandom_range(0, 63)) : 0;
                bus = walk_level + jitter;
                push_sample(walk_level, (bus > MAX_SAMPLE) ? MAX_SAMPLE : bus);
            end
        end
    endfunction

    task automatic wait_drained();
        while (sample_q.size() != 0 || offer_busy || window_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CODE_W-1:0] base, input logic [CODE_W-1:0] top,
                              input logic [STREAK_W-1:0] limit, input bit poke_unused);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE_STEP;
        i_cfg_data <= base;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_STEP;
        i_cfg_data <= top;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_STREAK_LIMIT;
        i_cfg_data <= CFG_DATA_W'(limit);
        if (poke_unused) begin
            @(posedge i_clk);
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= '1;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        trk_cfg.base_step    = base;
        trk_cfg.max_step     = top;
        trk_cfg.streak_limit = limit;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            tx_gap = 0;
            offer_busy = 1'b0;
            acc_power  = '0;
            last_power = '0;
            acc_count  = '0;
            heading_up = 1'b1;
            prior_up   = 1'b1;
            streak_cnt = '0;
            cur_step   = STEP_RESET;
            dac_pos    = SETPOINT_RESET;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_sample(t_sample'(s_axis_tdata[2*SAMPLE_W-1:0]));
                offer_busy = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_axis_tdata  <= {2'b00, sample_q.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    offer_busy = 1'b1;
                end else begin
                    if (sample_q.size() != 0) begin
                        tx_gap = $urandom_range(0, 4);
                    end
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
                check_field("padding", 32'd0, 32'(m_axis_tdata[63:$bits(t_result)]));
                if (window_q.size() == 0) begin
                    $display("%0t: window item with none expected, expected nothing, actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    want = window_q.pop_front();
                    check_field("dac_code", 32'(want.dac_code), 32'(got.dac_code));
                    check_field("window_power", want.window_power, got.window_power);
                    check_field("moving_up", 32'(want.moving_up), 32'(got.moving_up));
                    check_field("step_size", 32'(want.step_size), 32'(got.step_size));
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                rx_gap = $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= (hold_left == 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go && !hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_BASE_STEP;
        i_cfg_data    = '0;

        trk_cfg.base_step    = BASE_RESET;
        trk_cfg.max_step     = MAX_RESET;
        trk_cfg.streak_limit = LIMIT_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: full-scale window, a drop to zero, mixed bit patterns,
        // another drop and two rising windows.
        idle_pct = 20;
        repeat (WINDOW_LEN) push_sample(MAX_SAMPLE, MAX_SAMPLE);
        repeat (WINDOW_LEN) push_sample(0, 0);
        push_sample(MAX_SAMPLE, 0);
        push_sample(0, MAX_SAMPLE);
        push_sample('h5555, 'h2aaa);
        push_sample('h2aaa, 'h5555);
        repeat (WINDOW_LEN) push_sample(1, 1);
        push_sample(MAX_SAMPLE, MAX_SAMPLE);
        push_sample('h4000, 'h4000);
        push_sample(1, MAX_SAMPLE);
        push_sample(MAX_SAMPLE, 1);
        repeat (WINDOW_LEN) push_sample(MAX_SAMPLE, MAX_SAMPLE);
        wait_drained();

        // The output is held off while items keep coming, so the pipe backs up.
        push_trend(8, 70, 3000);
        push_noise(8);
        @(posedge i_clk);
        hold_go <= 1'b1;
        wait_drained();

        // Zero streak limit and the top step limit drive the step into saturation.
        set_config(12'd1, 12'd4095, 8'd0, 1'b1);
        walk_level = 1000;
        push_trend(12, 100, 2500);
        push_noise(4);

        for (int k = 0; k < 6; k++) begin
            case (k)
                0: set_config(12'd4095, 12'd1, 8'd255, 1'b0);
                1: set_config(12'd1, 12'd1, 8'd1, 1'b0);
                2: set_config(12'd4095, 12'd4095, 8'd1, 1'b0);
                3: set_config(12'd16, 12'd512, 8'd2, 1'b0);
                default: set_config(CODE_W'($urandom_range(1, 4095)),
                                    CODE_W'($urandom_range(1, 4095)),
                                    STREAK_W'($urandom_range(1, 255)), 1'b0);
            endcase
            idle_pct = (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 10 : 30);
            push_trend(6, 60, 3000);
            push_noise(6);
            push_trend(3, 30, 3000);
        end

        // With no floor on the step, falling power halves it on every window
        // until it reaches zero and the setpoint stops moving.
        set_config(12'd0, 12'd4095, 8'd0, 1'b0);
        idle_pct = 0;
        walk_level = 1000;
        push_trend(14, 100, 2000);
        wait_drained();
        walk_level = MAX_SAMPLE;
        push_trend(14, 0, 2000);
        push_noise(8);
        wait_drained();

        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
